// ===== rtl/core/sab_pkg.sv =====
// Shared types and constants for the strobe/acknowledge byte sender.
`timescale 1ns / 1ps

package sab_pkg;

    // Command codes carried by an input transaction
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic REG_TIMEOUT_LIMIT  = 1'b0;
    localparam logic REG_DEBOUNCE_COUNT = 1'b1;

    // Configuration register widths and reset values
    localparam int          CFG_DATA_W           = 16;
    localparam logic [15:0] TIMEOUT_LIMIT_RESET  = 16'd1800;  // 30 * 60 ticks
    localparam logic [3:0]  DEBOUNCE_COUNT_RESET = 4'd1;

    // One input transaction
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic       counted;
        logic       ack_level;
    } sab_item_t;

    // One result transaction
    typedef struct packed {
        logic [7:0]  port_data;
        logic        strobe_n;
        logic        busy_res;
        logic        accepted;
        logic        timed_out;
        logic [31:0] running_sum;
    } sab_result_t;

    // Configuration values seen by the engine
    typedef struct packed {
        logic [15:0] timeout_limit;
        logic [3:0]  debounce_count;
    } sab_cfg_t;

endpackage

// ===== rtl/core/sab_if.sv =====
// Valid/ready channel interfaces for the input and result transactions.
`timescale 1ns / 1ps

interface sab_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       counted;
    logic       ack_level;

    modport source (output valid, command, data_byte, counted, ack_level, input ready);
    modport sink   (input valid, command, data_byte, counted, ack_level, output ready);
endinterface

interface sab_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  port_data;
    logic        strobe_n;
    logic        busy_res;
    logic        accepted;
    logic        timed_out;
    logic [31:0] running_sum;

    modport source (output valid, port_data, strobe_n, busy_res, accepted, timed_out,
                     running_sum, input ready);
    modport sink   (input valid, port_data, strobe_n, busy_res, accepted, timed_out,
                    running_sum, output ready);
endinterface

// ===== rtl/core/sab_in_stage.sv =====
// Input register: captures one transaction and holds it until the engine takes it.
`timescale 1ns / 1ps

module sab_in_stage
    import sab_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sab_in_if.sink      in_ch,
    input  logic        advance,
    output logic        item_valid,
    output sab_item_t   item
);

    logic      valid_reg;
    logic      valid_next;
    sab_item_t item_reg;
    logic      load;

    // Room whenever empty or the held transaction moves on this cycle
    assign in_ch.ready = !valid_reg || advance;
    assign load        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.command   <= in_ch.command;
            item_reg.data_byte <= in_ch.data_byte;
            item_reg.counted   <= in_ch.counted;
            item_reg.ack_level <= in_ch.ack_level;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/sab_engine.sv =====
// Handshake state, checksum and configuration registers with their update logic.
`timescale 1ns / 1ps

module sab_engine
    import sab_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  fire,
    input  sab_item_t             item,
    output sab_result_t           result
);

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_WAIT_ACK = 2'd1;
    localparam logic [1:0] PH_WAIT_REL = 2'd2;

    sab_cfg_t    cfg_reg;

    logic [1:0]  phase_reg,  phase_next;
    logic [7:0]  byte_reg,   byte_next;
    logic        strobe_reg, strobe_next;
    logic [15:0] wait_reg,   wait_next;
    logic [3:0]  match_reg,  match_next;
    logic        flag_reg,   flag_next;
    logic [31:0] sum_reg,    sum_next;
    logic        acc;

    logic        waiting;
    logic        want;
    logic [3:0]  need;
    logic [15:0] lim;
    logic [3:0]  match_upd;
    logic [15:0] wait_upd;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_limit  <= TIMEOUT_LIMIT_RESET;
            cfg_reg.debounce_count <= DEBOUNCE_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIMEOUT_LIMIT:  cfg_reg.timeout_limit  <= cfg_data;
                REG_DEBOUNCE_COUNT: cfg_reg.debounce_count <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Zero limits act as one
    assign need = (cfg_reg.debounce_count == 4'd0) ? 4'd1 : cfg_reg.debounce_count;
    assign lim  = (cfg_reg.timeout_limit == 16'd0) ? 16'd1 : cfg_reg.timeout_limit;

    // Unused phase code counts as idle
    assign waiting = (phase_reg == PH_WAIT_ACK) || (phase_reg == PH_WAIT_REL);
    assign want    = (phase_reg == PH_WAIT_ACK);

    // Saturating debounce and wait counters for one sample
    assign match_upd = (item.ack_level != want) ? 4'd0 :
                       (match_reg == 4'hF)       ? match_reg : match_reg + 4'd1;
    assign wait_upd  = (wait_reg == 16'hFFFF) ? wait_reg : wait_reg + 16'd1;

    // Next state for one transaction
    always_comb
    begin
        phase_next  = phase_reg;
        byte_next   = byte_reg;
        strobe_next = strobe_reg;
        wait_next   = wait_reg;
        match_next  = match_reg;
        flag_next   = flag_reg;
        sum_next    = sum_reg;
        acc         = 1'b0;
        unique case (item.command)
            CMD_WRITE:
            begin
                if (!waiting && !flag_reg)
                begin
                    byte_next   = item.data_byte;
                    strobe_next = 1'b0;
                    if (item.counted)
                    begin
                        sum_next = sum_reg + {24'd0, item.data_byte};
                    end
                    phase_next  = PH_WAIT_ACK;
                    wait_next   = 16'd0;
                    match_next  = 4'd0;
                    acc         = 1'b1;
                end
            end
            CMD_TICK:
            begin
                if (waiting)
                begin
                    if (match_upd >= need)
                    begin
                        // Level held long enough: next phase
                        match_next = 4'd0;
                        wait_next  = 16'd0;
                        if (want)
                        begin
                            strobe_next = 1'b1;
                            phase_next  = PH_WAIT_REL;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    else if (wait_upd >= lim)
                    begin
                        // Wait ran out: release and flag
                        strobe_next = 1'b1;
                        flag_next   = 1'b1;
                        phase_next  = PH_IDLE;
                        wait_next   = 16'd0;
                        match_next  = 4'd0;
                    end
                    else
                    begin
                        match_next = match_upd;
                        wait_next  = wait_upd;
                    end
                end
            end
            CMD_CLEAR:
            begin
                sum_next  = 32'd0;
                flag_next = 1'b0;
            end
            default: ;
        endcase
    end

    // State registers advance once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            byte_reg   <= 8'd0;
            strobe_reg <= 1'b1;
            wait_reg   <= 16'd0;
            match_reg  <= 4'd0;
            flag_reg   <= 1'b0;
            sum_reg    <= 32'd0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            byte_reg   <= byte_next;
            strobe_reg <= strobe_next;
            wait_reg   <= wait_next;
            match_reg  <= match_next;
            flag_reg   <= flag_next;
            sum_reg    <= sum_next;
        end
    end

    // Result shows the state after the update
    always_comb
    begin
        result.port_data   = byte_next;
        result.strobe_n    = strobe_next;
        result.busy_res    = (phase_next == PH_WAIT_ACK) || (phase_next == PH_WAIT_REL);
        result.accepted    = acc;
        result.timed_out   = flag_next;
        result.running_sum = sum_next;
    end

endmodule

// ===== rtl/core/sab_out_stage.sv =====
// Result register: holds one result transaction until the receiver takes it.
`timescale 1ns / 1ps

module sab_out_stage
    import sab_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load_valid,
    input  sab_result_t result,
    output logic        free,
    sab_out_if.source   out_ch
);

    logic        valid_reg;
    logic        valid_next;
    sab_result_t result_reg;
    logic        load;

    // Free when empty or the held result leaves this cycle
    assign free = !valid_reg || out_ch.ready;
    assign load = load_valid && free;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_ch.valid       = valid_reg;
    assign out_ch.port_data   = result_reg.port_data;
    assign out_ch.strobe_n    = result_reg.strobe_n;
    assign out_ch.busy_res    = result_reg.busy_res;
    assign out_ch.accepted    = result_reg.accepted;
    assign out_ch.timed_out   = result_reg.timed_out;
    assign out_ch.running_sum = result_reg.running_sum;

endmodule

// ===== rtl/core/strobe_ack_byte_sender.sv =====
// Top level of the strobe/acknowledge parallel byte sender.
//
// Usage:
//   in_ch carries one command per transaction: write a byte, tick with an
//   acknowledge sample, or clear the checksum and timeout flag.
//   out_ch returns exactly one result per command: data lines, strobe level,
//   busy, whether a write was taken, the sticky timeout flag and the sum.
//   cfg_we/cfg_index/cfg_data write timeout_limit (index 0) and
//   debounce_count (index 1); write only while no command is in flight.
// Timing:
//   An accepted command lands in the input register, moves into the result
//   register once that register is free and shows on out_ch from then on.
//   One command per cycle is sustained while out_ch.ready stays high; the
//   state update is a single pass of logic between the two registers.
// Reset:
//   rst_n clears both registers' valid bits, idles the handshake with
//   strobe released, zeroes sum and flag, and loads the default config.
// Stalls:
//   While out_ch.ready is low the result holds; the input register takes
//   one more command, then in_ch.ready drops until the result is taken.
`timescale 1ns / 1ps

module strobe_ack_byte_sender
    import sab_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    sab_in_if.sink                in_ch,
    sab_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic        item_valid;
    sab_item_t   item;
    logic        free;
    logic        fire;
    sab_result_t result;

    // Transaction moves from input to result register
    assign fire = item_valid && free;

    sab_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .advance    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    sab_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item),
        .result    (result)
    );

    sab_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (item_valid),
        .result     (result),
        .free       (free),
        .out_ch     (out_ch)
    );

endmodule

// ===== rtl/core/sab_checker.sv =====
// Port-level checks for the byte sender, bound to the top level.
`timescale 1ns / 1ps

module sab_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  port_data,
    input logic        strobe_n,
    input logic        busy_res,
    input logic        accepted,
    input logic        timed_out,
    input logic [31:0] running_sum
);

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(port_data) && $stable(running_sum)
            && $stable(strobe_n) && $stable(busy_res))
        else $error("result payload changed while stalled");

    // A taken write starts a handshake with strobe driven
    a_accept_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> !strobe_n && busy_res && !timed_out)
        else $error("taken write without active strobe");

    // Strobe is only driven during a handshake
    a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> strobe_n)
        else $error("strobe driven while idle");

    // A timed-out sender is idle with strobe released
    a_timeout_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timed_out |-> !busy_res && strobe_n)
        else $error("handshake active while timed out");

endmodule

bind strobe_ack_byte_sender sab_checker u_sab_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .port_data   (out_ch.port_data),
    .strobe_n    (out_ch.strobe_n),
    .busy_res    (out_ch.busy_res),
    .accepted    (out_ch.accepted),
    .timed_out   (out_ch.timed_out),
    .running_sum (out_ch.running_sum)
);

// ===== verif/strobe_ack_byte_sender_test.sv =====
// Self-checking testbench for the strobe/acknowledge parallel byte sender.
`timescale 1ns / 1ps

module strobe_ack_byte_sender_test;
    import sab_pkg::*;

    // Handshake phases of the predicted sender
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT_ACK,
        PH_WAIT_REL
    } sender_phase_e;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SEGMENTS    = 9;
    localparam int SEG_ITEMS   = 211;

    // Predicts the sender state per command and checks returned transactions
    class sender_scoreboard;
        logic [15:0]   timeout_limit;
        logic [3:0]    debounce_count;
        sender_phase_e phase;
        logic [7:0]    data_lines;
        logic          strobe_level;
        logic [15:0]   tick_count;
        logic [3:0]    stable_run;
        logic          timeout_flag;
        logic [31:0]   byte_sum;
        sab_result_t   expected_results[$];
        int            errors;
        int            results_checked;
        int            writes_taken;
        int            timeouts_seen;
        bit            last_effective;

        function new();
            timeout_limit   = TIMEOUT_LIMIT_RESET;
            debounce_count  = DEBOUNCE_COUNT_RESET;
            phase           = PH_IDLE;
            data_lines      = 8'h00;
            strobe_level    = 1'b1;
            tick_count      = 16'h0000;
            stable_run      = 4'h0;
            timeout_flag    = 1'b0;
            byte_sum        = 32'h0;
            errors          = 0;
            results_checked = 0;
            writes_taken    = 0;
            timeouts_seen   = 0;
            last_effective  = 1'b0;
        endfunction

        function void set_config(logic [15:0] limit, logic [3:0] debounce);
            timeout_limit  = limit;
            debounce_count = debounce;
        endfunction

        function int needed_run();
            return (debounce_count == 4'd0) ? 1 : int'(debounce_count);
        endfunction

        function int tick_limit();
            return (timeout_limit == 16'd0) ? 1 : int'(timeout_limit);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // One acknowledge sample; want is the level that ends the current wait
        function void sample_ack(logic ack, logic want);
            if (ack == want) begin
                if (stable_run < 4'd15)
                    stable_run++;
            end
            else
                stable_run = 4'd0;
            if (int'(stable_run) >= needed_run()) begin
                stable_run = 4'd0;
                tick_count = 16'd0;
                if (phase == PH_WAIT_ACK) begin
                    strobe_level = 1'b1;
                    phase        = PH_WAIT_REL;
                end
                else
                    phase = PH_IDLE;
                return;
            end
            if (tick_count < 16'hFFFF)
                tick_count++;
            // give up on the wait; flag stays until cleared
            if (int'(tick_count) >= tick_limit()) begin
                strobe_level = 1'b1;
                timeout_flag = 1'b1;
                phase        = PH_IDLE;
                tick_count   = 16'd0;
                stable_run   = 4'd0;
                timeouts_seen++;
            end
        endfunction

        // Accepted input transaction: update state, queue the expected result
        function void note_command(sab_item_t it);
            sab_result_t r;
            r.accepted     = 1'b0;
            last_effective = 1'b1;
            case (it.command)
                CMD_WRITE: begin
                    if (phase == PH_IDLE && !timeout_flag) begin
                        data_lines   = it.data_byte;
                        strobe_level = 1'b0;
                        if (it.counted)
                            byte_sum = byte_sum + {24'd0, it.data_byte};
                        phase      = PH_WAIT_ACK;
                        tick_count = 16'd0;
                        stable_run = 4'd0;
                        r.accepted = 1'b1;
                        writes_taken++;
                    end
                    else
                        last_effective = 1'b0;
                end
                CMD_TICK: begin
                    if (phase == PH_WAIT_ACK)
                        sample_ack(it.ack_level, 1'b1);
                    else if (phase == PH_WAIT_REL)
                        sample_ack(it.ack_level, 1'b0);
                    else
                        last_effective = 1'b0;
                end
                CMD_CLEAR: begin
                    byte_sum     = 32'd0;
                    timeout_flag = 1'b0;
                end
                default: last_effective = 1'b0;
            endcase
            r.port_data   = data_lines;
            r.strobe_n    = strobe_level;
            r.busy_res    = (phase != PH_IDLE);
            r.timed_out   = timeout_flag;
            r.running_sum = byte_sum;
            expected_results.push_back(r);
        endfunction

        function string show(sab_result_t r);
            return $sformatf("data %02h strobe_n %b busy %b acc %b tmo %b sum %08h",
                             r.port_data, r.strobe_n, r.busy_res, r.accepted,
                             r.timed_out, r.running_sum);
        endfunction

        function void report(string what);
            errors++;
            if (errors <= 10)
                $display("MISMATCH %0d at %0t: %s", errors, $time, what);
        endfunction

        // Returned result transaction against the oldest expectation
        function void check_result(sab_result_t got);
            sab_result_t want;
            results_checked++;
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result %s", show(got)));
                return;
            end
            want = expected_results.pop_front();
            if (got.port_data !== want.port_data || got.strobe_n !== want.strobe_n ||
                got.busy_res !== want.busy_res || got.accepted !== want.accepted ||
                got.timed_out !== want.timed_out || got.running_sum !== want.running_sum)
                report($sformatf("expected %s, got %s", show(want), show(got)));
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_index;
    logic [15:0]      cfg_data;
    sab_in_if         in_ch();
    sab_out_if        out_ch();
    sender_scoreboard sb;
    int               src_idle_pct;
    int               snk_idle_pct;
    int               cycle_count;
    int               items_total;
    int               items_effective;
    int               settings_used;
    int               seg_limit[SEGMENTS]    = '{65535, 1, 6, 40, 0, 12, 65535, 3, 25};
    int               seg_debounce[SEGMENTS] = '{15, 1, 3, 15, 0, 2, 1, 4, 7};

    strobe_ack_byte_sender DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random back-pressure, check at the rising edge
    initial
    begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready) begin : take_result
                sab_result_t got;
                got.port_data   = out_ch.port_data;
                got.strobe_n    = out_ch.strobe_n;
                got.busy_res    = out_ch.busy_res;
                got.accepted    = out_ch.accepted;
                got.timed_out   = out_ch.timed_out;
                got.running_sum = out_ch.running_sum;
                sb.check_result(got);
            end
            @(negedge clk);
            out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Drive one command transaction; returns at the edge where it was taken
    task automatic send(input logic [1:0] cmd, input logic [7:0] data,
                        input logic cnt, input logic ack);
        sab_item_t it;
        it.command   = cmd;
        it.data_byte = data;
        it.counted   = cnt;
        it.ack_level = ack;
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid     <= 1'b0;
            in_ch.command   <= 2'($urandom);
            in_ch.data_byte <= 8'($urandom);
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.command   <= cmd;
        in_ch.data_byte <= data;
        in_ch.counted   <= cnt;
        in_ch.ack_level <= ack;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_command(it);
        items_total++;
        if (sb.last_effective)
            items_effective++;
    endtask

    task automatic tick(input logic ack);
        send(CMD_TICK, 8'($urandom), 1'($urandom), ack);
    endtask

    task automatic send_noise();
        send(2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // Registers change only with nothing in flight
    task automatic write_config(input logic [15:0] limit, input logic [3:0] debounce);
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TIMEOUT_LIMIT;
        cfg_data  <= limit;
        @(negedge clk);
        cfg_index <= REG_DEBOUNCE_COUNT;
        cfg_data  <= {12'($urandom), debounce};
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_config(limit, debounce);
        settings_used++;
    endtask

    // Tick until the current wait ends, with bounce, noise or a dead line
    task automatic ack_wait(input logic want);
        sender_phase_e start;
        int            cap;
        int            bounce;
        int            k;
        bit            stuck;
        start  = sb.phase;
        stuck  = ($urandom_range(0, 99) < 8);
        bounce = 2 + 30 / sb.needed_run();
        cap    = stuck ? ((sb.tick_limit() < 60) ? sb.tick_limit() + 1 : 40)
                       : 3 * sb.needed_run() + 6;
        k      = 0;
        while (start != PH_IDLE && sb.phase == start && k < cap) begin
            if ($urandom_range(0, 99) < 3)
                send_noise();
            else
                tick((stuck || $urandom_range(0, 99) < bounce) ? !want : want);
            k++;
        end
    endtask

    // One byte transfer: write, acknowledge wait, release wait
    task automatic run_transfer();
        if (sb.timeout_flag && $urandom_range(0, 9) < 8)
            send(CMD_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
        send(CMD_WRITE, 8'($urandom), 1'($urandom), 1'($urandom));
        ack_wait(1'b1);
        ack_wait(1'b0);
    endtask

    initial
    begin : stimulus
        int target;
        sb              = new();
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.command   = CMD_WRITE;
        in_ch.data_byte = 8'h00;
        in_ch.counted   = 1'b0;
        in_ch.ack_level = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_TIMEOUT_LIMIT;
        cfg_data        = 16'h0000;
        cycle_count     = 0;
        items_total     = 0;
        items_effective = 0;
        settings_used   = 0;
        src_idle_pct    = 22;
        snk_idle_pct    = 62;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Full handshake at reset settings, refused write while busy,
        // clear in mid-handshake, idle tick and the unused command code
        send(CMD_WRITE, 8'hFF, 1'b1, 1'b0);
        send(CMD_WRITE, 8'h55, 1'b1, 1'b1);
        tick(1'b0);
        send(CMD_CLEAR, 8'h00, 1'b0, 1'b0);
        tick(1'b1);
        tick(1'b1);
        tick(1'b0);
        tick(1'b1);
        send(2'd3, 8'hAA, 1'b1, 1'b1);
        send(CMD_WRITE, 8'h00, 1'b0, 1'b1);
        tick(1'b1);
        tick(1'b0);

        // Shortest limit: timeout in the acknowledge wait, write refused while flagged
        write_config(16'd1, 4'd2);
        send(CMD_WRITE, 8'h80, 1'b1, 1'b0);
        tick(1'b1);
        send(CMD_WRITE, 8'h01, 1'b1, 1'b0);
        send(CMD_CLEAR, 8'hFF, 1'b1, 1'b1);
        send(CMD_WRITE, 8'h7F, 1'b1, 1'b1);
        tick(1'b0);
        send(CMD_CLEAR, 8'h00, 1'b0, 1'b0);

        // Zero in both registers acts as one
        write_config(16'd0, 4'd0);
        send(CMD_WRITE, 8'hFE, 1'b1, 1'b0);
        tick(1'b1);
        tick(1'b0);
        send(CMD_WRITE, 8'h01, 1'b0, 1'b0);
        tick(1'b0);
        send(CMD_CLEAR, 8'h00, 1'b0, 1'b0);

        // Random transfers over a range of settings and idle patterns
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            write_config(16'(seg_limit[seg]), 4'(seg_debounce[seg]));
            case (seg / 3)
                0: begin src_idle_pct = 22; snk_idle_pct = 62; end
                1: begin src_idle_pct = 62; snk_idle_pct = 22; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            target = items_effective + SEG_ITEMS;
            while (items_effective < target) begin
                if ($urandom_range(0, 99) < 15)
                    send_noise();
                else
                    run_transfer();
            end
        end

        // Drain
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d commands (%0d with effect) over %0d register settings",
                 items_total, items_effective, settings_used);
        $display("%0d writes taken, %0d timeouts, %0d results compared, %0d mismatches",
                 sb.writes_taken, sb.timeouts_seen, sb.results_checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
